FILE: rtl/mst_pkg.sv
package mst_pkg;

    // Width of the reported tree weight and its saturation value
    localparam int TOTAL_BITS = 20;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 20'hFFFFF;

    // Command codes on the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_RUN    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Controls from the sequencer to the relax/compare stage
    typedef struct packed {
        logic clear;   // start of a pass: reset running minimum
        logic init;    // first pass of a run: take edge row as distances
        logic valid;   // read data for one vertex is on the memory outputs
    } relax_ctl_t;

endpackage

FILE: rtl/mst_ram.sv
module mst_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mst_relax.sv
module mst_relax #(
    parameter int VW = 4,
    parameter int DW = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mst_pkg::relax_ctl_t    ctl,
    input  logic [VW-1:0]          idx,
    input  logic                   idx_visited,
    input  logic [DW-1:0]          edge_d,
    input  logic [DW-1:0]          best_d,
    output logic [DW-1:0]          new_d,
    output logic [DW-1:0]          min_d,
    output logic [VW-1:0]          pick,
    output logic                   found
);

    localparam logic [DW-1:0] NoEdge = {1'b1, {(DW-1){1'b0}}};

    logic [DW-1:0] min_reg;
    logic [VW-1:0] pick_reg;
    logic          found_reg;
    logic          take;

    // Relax one vertex against the newest tree row
    always_comb
    begin
        if (ctl.init)
        begin
            new_d = edge_d;
        end
        else if (!idx_visited && (edge_d < best_d))
        begin
            new_d = edge_d;
        end
        else
        begin
            new_d = best_d;
        end
        take = ctl.valid && !idx_visited && (new_d < min_reg);
    end

    // Running minimum; strict compare keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            min_reg   <= NoEdge;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
            min_reg   <= NoEdge;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
            min_reg   <= new_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pick_reg <= idx;
        end
    end

    assign min_d = min_reg;
    assign pick  = pick_reg;
    assign found = found_reg;

endmodule

FILE: rtl/prim_minimum_spanning_tree.sv
// Prim spanning tree engine over a weighted adjacency matrix held in a
// synchronous RAM of 2^(2*ceil(log2 MAX_VERTICES)) words (256 by default).
// After reset the matrix RAM is swept to "no edge", one word a cycle;
// in_ready stays low meanwhile. An insert with valid vertices does two
// RAM writes, a clear repeats the sweep. A run of n vertices does one pass
// over n vertices per vertex added: each pass reads a matrix row and the
// distance RAM one vertex a cycle, relaxes and tracks the minimum; a tree
// word waits while the output is stalled. Each item is answered by one or
// more words on the output channel; acknowledgements carry last = 1.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [4:0]  vertex_a,
    input  logic [4:0]  vertex_b,
    input  logic [15:0] edge_weight,
    input  logic [3:0]  start_vertex,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  tree_vertex,
    output logic        last,
    output logic [19:0] total_weight,
    output logic        disconnected
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;
    localparam int DW = WEIGHT_BITS + 1;
    localparam int TB = mst_pkg::TOTAL_BITS;
    localparam int TW = ((WEIGHT_BITS > TB) ? WEIGHT_BITS : TB) + 1;
    localparam logic [DW-1:0] NoEdge = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_INS    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [4:0]              vertex_count_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CW-1:0]           j_reg;
    logic [CW-1:0]           joined_reg;
    logic                    s1_valid_reg;
    logic [VW-1:0]           s1_idx_reg;
    logic                    init_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [TB-1:0]           total_reg;
    logic [VW-1:0]           row_reg;
    logic [VW-1:0]           pend_reg;
    logic [VW-1:0]           ins_a_reg;
    logic [VW-1:0]           ins_b_reg;
    logic [WEIGHT_BITS-1:0]  ins_w_reg;

    logic                    out_valid_reg;
    logic [3:0]              out_vertex_reg;
    logic                    out_last_reg;
    logic [TB-1:0]           out_total_reg;
    logic                    out_disc_reg;

    logic                    accept;
    logic                    out_free;
    logic [CW-1:0]           n_eff;
    logic                    range_ok;
    logic                    root_ok;
    logic [VW-1:0]           a_idx;
    logic [VW-1:0]           b_idx;
    logic [VW-1:0]           root_idx;
    logic [WEIGHT_BITS-1:0]  w_in;
    logic                    issue;
    logic                    start_run;
    logic                    grow;
    logic                    emit;
    logic [3:0]              emit_vertex;
    logic                    emit_last;
    logic [TB-1:0]           emit_total;
    logic                    emit_disc;
    logic [TW-1:0]           sum_wide;
    logic [TB-1:0]           total_sat;

    logic                    e_we;
    logic [AW-1:0]           e_waddr;
    logic [DW-1:0]           e_wdata;
    logic [DW-1:0]           e_rdata;
    logic [DW-1:0]           b_rdata;

    mst_pkg::relax_ctl_t     ctl;
    logic [DW-1:0]           relax_new;
    logic [DW-1:0]           relax_min;
    logic [VW-1:0]           relax_pick;
    logic                    relax_found;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Vertex count in effect, clamped to 1..MAX_VERTICES
    always_comb
    begin
        if (vertex_count_reg == 5'd0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(vertex_count_reg) > MAX_VERTICES)
        begin
            n_eff = CW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CW'(vertex_count_reg);
        end
    end

    // Input decode
    assign range_ok = (vertex_a != 5'd0) && (32'(vertex_a) <= MAX_VERTICES) &&
                      (vertex_b != 5'd0) && (32'(vertex_b) <= MAX_VERTICES);
    assign root_ok  = 32'(start_vertex) < 32'(n_eff);
    assign a_idx    = VW'(vertex_a - 5'd1);
    assign b_idx    = VW'(vertex_b - 5'd1);
    assign root_idx = VW'(start_vertex);
    assign w_in     = WEIGHT_BITS'(edge_weight);
    assign issue    = j_reg < n_eff;

    // Saturating tree weight
    assign sum_wide  = TW'(total_reg) + TW'(relax_min[WEIGHT_BITS-1:0]);
    assign total_sat = (sum_wide > TW'(mst_pkg::TOTAL_MAX)) ? mst_pkg::TOTAL_MAX
                                                            : TB'(sum_wide);

    // Sequencer, output word selection and matrix write port
    always_comb
    begin
        state_next  = state_reg;
        start_run   = 1'b0;
        grow        = 1'b0;
        emit        = 1'b0;
        emit_vertex = 4'd0;
        emit_last   = 1'b1;
        emit_total  = '0;
        emit_disc   = 1'b0;
        e_we        = 1'b0;
        e_waddr     = clr_addr_reg;
        e_wdata     = NoEdge;
        case (state_reg)
            ST_CLEAR:
            begin
                e_we = 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        mst_pkg::MODE_INSERT:
                        begin
                            emit = 1'b1;
                            if (range_ok)
                            begin
                                e_we       = 1'b1;
                                e_waddr    = {a_idx, b_idx};
                                e_wdata    = {1'b0, w_in};
                                state_next = ST_INS;
                            end
                        end
                        mst_pkg::MODE_RUN:
                        begin
                            if (root_ok)
                            begin
                                start_run  = 1'b1;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_disc = 1'b1;
                            end
                        end
                        mst_pkg::MODE_CLEAR:
                        begin
                            emit       = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                e_we       = 1'b1;
                e_waddr    = {ins_b_reg, ins_a_reg};
                e_wdata    = {1'b0, ins_w_reg};
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!issue && !s1_valid_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // Previous tree vertex goes out once we know if it is the last
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_vertex = 4'(pend_reg);
                    if (relax_found)
                    begin
                        grow       = 1'b1;
                        emit_last  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        emit_total = total_reg;
                        emit_disc  = joined_reg != n_eff;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            vertex_count_reg <= 5'd16;
            visited_reg      <= '0;
            j_reg            <= '0;
            joined_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            init_reg         <= 1'b0;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wen)
            begin
                vertex_count_reg <= cfg_wdata;
            end

            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else
            begin
                clr_addr_reg <= '0;
            end

            if (start_run || grow)
            begin
                j_reg <= '0;
            end
            else if ((state_reg == ST_SCAN) && issue)
            begin
                j_reg <= j_reg + CW'(1);
            end
            s1_valid_reg <= (state_reg == ST_SCAN) && issue;

            if (start_run)
            begin
                init_reg    <= 1'b1;
                visited_reg <= MAX_VERTICES'(1) << root_idx;
                joined_reg  <= CW'(1);
            end
            else if (grow)
            begin
                init_reg    <= 1'b0;
                visited_reg <= visited_reg | (MAX_VERTICES'(1) << relax_pick);
                joined_reg  <= joined_reg + CW'(1);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= j_reg[VW-1:0];
        if (accept)
        begin
            ins_a_reg <= a_idx;
            ins_b_reg <= b_idx;
            ins_w_reg <= w_in;
        end
        if (start_run)
        begin
            row_reg   <= root_idx;
            pend_reg  <= root_idx;
            total_reg <= '0;
        end
        else if (grow)
        begin
            row_reg   <= relax_pick;
            pend_reg  <= relax_pick;
            total_reg <= total_sat;
        end
        if (emit)
        begin
            out_vertex_reg <= emit_vertex;
            out_last_reg   <= emit_last;
            out_total_reg  <= emit_total;
            out_disc_reg   <= emit_disc;
        end
    end

    // Adjacency matrix, row-major by {row, column}
    mst_ram #(
        .WIDTH (DW),
        .DEPTH (1 << AW)
    ) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr ({row_reg, j_reg[VW-1:0]}),
        .rdata (e_rdata)
    );

    // Best known distance of each vertex to the tree
    mst_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_best_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (relax_new),
        .raddr (j_reg[VW-1:0]),
        .rdata (b_rdata)
    );

    assign ctl.clear = start_run || grow;
    assign ctl.init  = init_reg;
    assign ctl.valid = s1_valid_reg;

    mst_relax #(
        .VW (VW),
        .DW (DW)
    ) u_relax (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .idx         (s1_idx_reg),
        .idx_visited (visited_reg[s1_idx_reg]),
        .edge_d      (e_rdata),
        .best_d      (b_rdata),
        .new_d       (relax_new),
        .min_d       (relax_min),
        .pick        (relax_pick),
        .found       (relax_found)
    );

    assign out_valid    = out_valid_reg;
    assign tree_vertex  = out_vertex_reg;
    assign last         = out_last_reg;
    assign total_weight = out_total_reg;
    assign disconnected = out_disc_reg;

endmodule
